[hw/rtl/ksg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ksg_pkg
// shared types, command codes, key map and quarter-wave sine math for the
// keyed sine tone generator
// ----------------------------------------------------------------------------
package ksg_pkg;

    typedef logic [1:0]  t_op;
    typedef logic [7:0]  t_key;
    typedef logic [14:0] t_gain;
    typedef logic [15:0] t_sample;

    // command codes
    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_PRESS   = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;

    localparam t_gain GAIN_RESET = 15'd22938;

    // key map: a w s e d f t g y h u j k -> C4 .. C5, q -> 0 Hz
    localparam int unsigned KEY_COUNT = 13;
    localparam t_key KEY_QUIT = 8'h71;
    localparam t_key KEY_CHARS [KEY_COUNT] = '{
        8'h61, 8'h77, 8'h73, 8'h65, 8'h64, 8'h66, 8'h74,
        8'h67, 8'h79, 8'h68, 8'h75, 8'h6a, 8'h6b
    };
    // note frequencies in hundredths of a hertz
    localparam logic [15:0] KEY_CENTIHZ [KEY_COUNT] = '{
        16'd26163, 16'd27718, 16'd29366, 16'd31113, 16'd32963, 16'd34923, 16'd36999,
        16'd39200, 16'd41530, 16'd44000, 16'd46616, 16'd49388, 16'd52325
    };

    // taylor coefficients of sin(pi/2 x), q30 magnitudes
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598668;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026995;
    localparam logic [63:0] SC9 = 64'd172272;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // sin(pi/2 x) for x in q30 within [0, 1], result in q15 (0..32767)
    // only evaluated on constants, so it folds into a table
    function automatic t_gain quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = SC7 - ((x2 * SC9) >> 30);
        t  = SC5 - ((x2 * t) >> 30);
        t  = SC3 - ((x2 * t) >> 30);
        t  = SC1 - ((x2 * t) >> 30);
        t  = (x * t) >> 30;
        if (t > Q30_ONE) begin
            t = Q30_ONE;
        end
        t = (t + 64'd16384) >> 15;
        if (t > 64'd32767) begin
            t = 64'd32767;
        end
        return t[14:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ksg_cmd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ksg_cmd_if
// command channel: sample ticks, key presses and key releases
// ----------------------------------------------------------------------------
interface ksg_cmd_if
    import ksg_pkg::*;
();
    logic valid;
    logic ready;
    t_op  op;
    t_key key_code;

    modport source (output valid, output op, output key_code, input ready);
    modport sink   (input valid, input op, input key_code, output ready);
endinterface
`default_nettype wire

[hw/rtl/ksg_tone_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ksg_tone_if
// audio sample channel, one signed q1.15 sample per beat
// ----------------------------------------------------------------------------
interface ksg_tone_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

[hw/rtl/ksg_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ksg_cfg_if
// volume gain write channel
// ----------------------------------------------------------------------------
interface ksg_cfg_if
    import ksg_pkg::*;
();
    logic  valid;
    logic  ready;
    t_gain volume_gain;

    modport source (output valid, output volume_gain, input ready);
    modport sink   (input valid, input volume_gain, output ready);
endinterface
`default_nettype wire

[hw/rtl/keyed_sine_tone_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_sine_tone_generator
// keyboard driven direct digital synthesis sine oscillator
// ----------------------------------------------------------------------------
// A key press on i_cmd picks one of thirteen semitones from C4 to C5 ('q'
// gives 0 Hz, other keys keep the current note) and starts playback; a release
// of the held key stops it. Every tick beat taken while playing advances the
// phase accumulator by the note's tuning word and yields one sample on o_tone,
// the sine of the new phase scaled by the volume gain; ticks while silent are
// consumed with no output and the phase holds. The block takes one command
// beat per clock while i_cmd ready is high: key state and phase update at the
// edge that takes the beat, and a tick's sample goes through the pending tick
// stage into the o_tone output register, from which it is offered. The single
// stage between the phase snapshot and the output register (quarter-wave
// table read, one 15x15 gain multiply with rounding, sign) is combinational.
// Stall on o_tone holds the output register and one pending tick; i_cmd
// ready drops only when both are full. i_cfg is always ready and should be
// written only while no sample is pending.
// ----------------------------------------------------------------------------
module keyed_sine_tone_generator
    import ksg_pkg::*;
#(
    parameter int unsigned SAMPLE_RATE     = 44100,
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned SINE_TABLE_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ksg_cmd_if.sink     i_cmd,
    ksg_cfg_if.sink     i_cfg,
    ksg_tone_if.source  o_tone
);

    localparam int unsigned QB      = SINE_TABLE_BITS - 2;   // bits within a quarter
    localparam int unsigned QSIZE   = 1 << QB;
    localparam int unsigned KEY_IW  = $clog2(KEY_COUNT);
    localparam logic [79:0] TW_DEN  = 80'(100 * SAMPLE_RATE);
    localparam logic [79:0] TW_HALF = 80'(50 * SAMPLE_RATE);

    // tuning words per key, folded at elaboration: round(f * 2^P / rate)
    logic [PHASE_BITS-1:0] w_tw [KEY_COUNT];
    for (genvar gk = 0; gk < KEY_COUNT; gk++) begin : g_tw
        localparam logic [79:0] NUM = (80'(KEY_CENTIHZ[gk]) << PHASE_BITS) + TW_HALF;
        localparam logic [79:0] TW  = NUM / TW_DEN;
        assign w_tw[gk] = TW[PHASE_BITS-1:0];
    end

    // quarter-wave table, one entry past the quarter for the mirrored peak
    t_gain w_rom [QSIZE+1];
    for (genvar gq = 0; gq <= QSIZE; gq++) begin : g_rom
        assign w_rom[gq] = quarter_sine(64'(gq) << (30 - QB));
    end

    // ---------------- key state and phase ----------------
    logic                  r_playing;
    t_key                  r_held;
    logic [PHASE_BITS-1:0] r_tw;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    t_gain                 r_gain;

    // pending tick stage: sine index of the new phase
    logic                       r_a_vld;
    logic [SINE_TABLE_BITS-1:0] r_a_idx;

    // output register
    logic           r_out_vld;
    t_sample        r_out;

    logic w_out_adv;
    logic w_a_free;
    logic w_cmd_acc;
    logic w_tick_fire;

    // key lookup
    logic              w_hit;
    logic [KEY_IW-1:0] w_kidx;

    assign w_out_adv   = !r_out_vld || o_tone.ready;
    assign w_a_free    = !r_a_vld || w_out_adv;
    assign i_cmd.ready = w_a_free;
    assign w_cmd_acc   = i_cmd.valid && w_a_free;
    assign w_tick_fire = w_cmd_acc && (i_cmd.op == OP_TICK) && r_playing;
    assign n_phase     = r_phase + r_tw;

    always_comb begin
        w_hit  = 1'b0;
        w_kidx = '0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (i_cmd.key_code == KEY_CHARS[i]) begin
                w_hit  = 1'b1;
                w_kidx = KEY_IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_held    <= '0;
            r_tw      <= '0;
            r_phase   <= '0;
        end else if (w_cmd_acc) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_playing) begin
                        r_phase <= n_phase;
                    end
                end
                OP_PRESS: begin
                    // a held key that is still sounding is key repeat
                    if (i_cmd.key_code != r_held || !r_playing) begin
                        if (i_cmd.key_code == KEY_QUIT) begin
                            r_tw <= '0;
                        end else if (w_hit) begin
                            r_tw <= w_tw[w_kidx];
                        end
                        r_held    <= i_cmd.key_code;
                        r_playing <= 1'b1;
                    end
                end
                OP_RELEASE: begin
                    if (i_cmd.key_code == r_held) begin
                        r_playing <= 1'b0;
                    end
                end
                default: begin
                    // unused code, dropped
                end
            endcase
        end
    end

    // volume register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg.valid) begin
            r_gain <= i_cfg.volume_gain;
        end
    end

    // ---------------- tick pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_a_free) begin
            r_a_vld <= w_tick_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick_fire) begin
            r_a_idx <= n_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
        end
    end

    // quadrant fold, table read, gain and sign
    logic [1:0]    w_quad;
    logic [QB-1:0] w_pos;
    logic [QB:0]   w_p;
    t_gain         w_sin;
    logic [29:0]   w_prod;
    logic [30:0]   w_rnd;
    t_sample       w_mag;
    t_sample       n_out;

    always_comb begin
        w_quad = r_a_idx[SINE_TABLE_BITS-1 -: 2];
        w_pos  = r_a_idx[QB-1:0];
        w_p    = w_quad[0] ? ((QB+1)'(QSIZE) - {1'b0, w_pos}) : {1'b0, w_pos};
        w_sin  = w_rom[w_p];
        w_prod = 30'(w_sin) * 30'(r_gain);
        w_rnd  = {1'b0, w_prod} + 31'd16384;
        w_mag  = w_rnd[30:15];
        n_out  = w_quad[1] ? (16'd0 - w_mag) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_adv) begin
            r_out_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_a_vld) begin
            r_out <= n_out;
        end
    end

    assign o_tone.valid  = r_out_vld;
    assign o_tone.sample = r_out;

`ifndef SYNTHESIS
    // a playing tick always lands in the pending stage
    a_tick_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_fire |=> r_a_vld)
        else $error("playing tick did not enter the pending stage");

    // the phase only moves on a playing tick
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tick_fire |=> $stable(r_phase))
        else $error("phase moved without a playing tick");

    // commands stall only when both the pending stage and the output are full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (r_a_vld && r_out_vld))
        else $error("command stall with a free stage");

    // releasing the held key silences the tone
    a_release_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_acc && (i_cmd.op == OP_RELEASE) && (i_cmd.key_code == r_held))
        |=> !r_playing)
        else $error("release of held key did not stop playback");
`endif

endmodule
`default_nettype wire
